### src/wdvr_pkg.sv
// Package with the item types and constants of the wet/dry velocity recovery core.
`timescale 1ns / 1ps

package wdvr_pkg;

   localparam int unsigned DATA_WIDTH = 32;
   localparam int unsigned THR_WIDTH = 31;
   localparam int unsigned DIV_STEPS = 32;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DRY_DEPTH_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STILL_VELOCITY_THRESHOLD = 2'd1;

   localparam logic [THR_WIDTH-1:0] THRESHOLD_RESET = 31'd17;

   localparam logic [DATA_WIDTH-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [DATA_WIDTH-1:0] SAT_NEG = 32'h8000_0000;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] rem;
      logic [DATA_WIDTH-1:0] lo;
      logic [DATA_WIDTH-1:0] quo;
      logic [DATA_WIDTH-1:0] mom;
      logic                  neg;
      logic                  over;
   } lane_type;

   typedef struct packed {
      lane_type              lane_x;
      lane_type              lane_y;
      logic [THR_WIDTH-1:0]  divisor;
      logic [DATA_WIDTH-1:0] depth;
      logic                  dry;
   } item_type;

endpackage

### src/wet_dry_velocity_recovery_core.sv
// Top level of the wet/dry velocity recovery core: thresholds, entry stage, divider chain, exit.
`timescale 1ns / 1ps

// Takes one cell per clock while the result side does not stall, and passes it through
// one entry stage, a chain of 32 divider cells that each settle one quotient
// bit of both velocities, and one result register. Every stage holds its own item and
// moves it on whenever the next stage is empty or moving, so a stall on the result side
// fills the chain before req_ready drops, and empty slots close up. Threshold writes take
// effect at the next clock and are meant for an empty pipeline.

module wet_dry_velocity_recovery_core #(
   parameter int unsigned FRAC_BITS = 24
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic signed [wdvr_pkg::DATA_WIDTH-1:0]      req_depth,
   input  logic signed [wdvr_pkg::DATA_WIDTH-1:0]      req_momentum_x,
   input  logic signed [wdvr_pkg::DATA_WIDTH-1:0]      req_momentum_y,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [wdvr_pkg::DATA_WIDTH-1:0]      rsp_depth_out,
   output logic signed [wdvr_pkg::DATA_WIDTH-1:0]      rsp_momentum_x_out,
   output logic signed [wdvr_pkg::DATA_WIDTH-1:0]      rsp_momentum_y_out,
   output logic signed [wdvr_pkg::DATA_WIDTH-1:0]      rsp_velocity_x,
   output logic signed [wdvr_pkg::DATA_WIDTH-1:0]      rsp_velocity_y,
   output logic                                        rsp_cell_dry,
   output logic                                        rsp_quotient_saturated,
   input  logic                                        csr_write_enable,
   input  logic [wdvr_pkg::CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [wdvr_pkg::THR_WIDTH-1:0]              csr_write_data
);
   import wdvr_pkg::*;

   logic [THR_WIDTH-1:0] dry_thr_ff, dry_thr_in;
   logic [THR_WIDTH-1:0] still_thr_ff, still_thr_in;

   logic     chain_valid [0:DIV_STEPS];
   logic     chain_ready [0:DIV_STEPS];
   item_type chain_item  [0:DIV_STEPS];

   always_comb begin
      dry_thr_in = dry_thr_ff;
      still_thr_in = still_thr_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DRY_DEPTH_THRESHOLD:      dry_thr_in = csr_write_data;
            CSR_STILL_VELOCITY_THRESHOLD: still_thr_in = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dry_thr_ff <= THRESHOLD_RESET;
         still_thr_ff <= THRESHOLD_RESET;
      end else begin
         dry_thr_ff <= dry_thr_in;
         still_thr_ff <= still_thr_in;
      end
   end

   wdvr_front #(
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .depth        (req_depth),
      .momentum_x   (req_momentum_x),
      .momentum_y   (req_momentum_y),
      .dry_threshold(dry_thr_ff),
      .out_valid    (chain_valid[0]),
      .out_ready    (chain_ready[0]),
      .out_item     (chain_item[0])
   );

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
      wdvr_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (chain_valid[k]),
         .in_ready (chain_ready[k]),
         .in_item  (chain_item[k]),
         .out_valid(chain_valid[k+1]),
         .out_ready(chain_ready[k+1]),
         .out_item (chain_item[k+1])
      );
   end

   wdvr_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .in_valid              (chain_valid[DIV_STEPS]),
      .in_ready              (chain_ready[DIV_STEPS]),
      .in_item               (chain_item[DIV_STEPS]),
      .still_threshold       (still_thr_ff),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_depth_out         (rsp_depth_out),
      .rsp_momentum_x_out    (rsp_momentum_x_out),
      .rsp_momentum_y_out    (rsp_momentum_y_out),
      .rsp_velocity_x        (rsp_velocity_x),
      .rsp_velocity_y        (rsp_velocity_y),
      .rsp_cell_dry          (rsp_cell_dry),
      .rsp_quotient_saturated(rsp_quotient_saturated)
   );

endmodule

### src/wdvr_front.sv
// Entry stage: dry check, momentum magnitudes, overflow detect and divider setup.
`timescale 1ns / 1ps

module wdvr_front #(
   parameter int unsigned FRAC_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [wdvr_pkg::DATA_WIDTH-1:0] depth,
   input  logic signed [wdvr_pkg::DATA_WIDTH-1:0] momentum_x,
   input  logic signed [wdvr_pkg::DATA_WIDTH-1:0] momentum_y,
   input  logic [wdvr_pkg::THR_WIDTH-1:0]      dry_threshold,
   output logic                                out_valid,
   input  logic                                out_ready,
   output wdvr_pkg::item_type                  out_item
);
   import wdvr_pkg::*;

   localparam int unsigned WIDE = 2 * DATA_WIDTH;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   function automatic lane_type make_lane(input logic [DATA_WIDTH-1:0] m,
                                          input logic [THR_WIDTH-1:0] d);
      lane_type              ln;
      logic [DATA_WIDTH-1:0] mag;
      logic [WIDE-1:0]       num;
      logic [WIDE-1:0]       den;
      mag = m[DATA_WIDTH-1] ? (~m + 1'b1) : m;
      num = WIDE'(mag) << FRAC_BITS;
      den = {1'b0, d, {DATA_WIDTH{1'b0}}};
      ln.rem = DATA_WIDTH'(mag >> (DATA_WIDTH - FRAC_BITS));
      ln.lo = num[DATA_WIDTH-1:0];
      ln.quo = '0;
      ln.mom = m;
      ln.neg = m[DATA_WIDTH-1];
      ln.over = (mag != '0) && (num >= den);
      return ln;
   endfunction

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      item_in.divisor = depth[THR_WIDTH-1:0];
      item_in.depth = depth;
      item_in.dry = depth[DATA_WIDTH-1] || (depth[THR_WIDTH-1:0] < dry_threshold);
      item_in.lane_x = make_lane(momentum_x, depth[THR_WIDTH-1:0]);
      item_in.lane_y = make_lane(momentum_y, depth[THR_WIDTH-1:0]);
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item = item_ff;

endmodule

### src/wdvr_div_cell.sv
// One restoring-division cell: resolves one quotient bit for both momentum lanes.
`timescale 1ns / 1ps

module wdvr_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  wdvr_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output wdvr_pkg::item_type out_item
);
   import wdvr_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   function automatic lane_type step_lane(input lane_type ln, input logic [THR_WIDTH-1:0] d);
      lane_type              nx;
      logic [DATA_WIDTH-1:0] trial;
      logic                  ge;
      nx = ln;
      trial = {ln.rem[DATA_WIDTH-2:0], ln.lo[DATA_WIDTH-1]};
      ge = trial >= {1'b0, d};
      nx.rem = ge ? (trial - {1'b0, d}) : trial;
      nx.quo = {ln.quo[DATA_WIDTH-2:0], ge};
      nx.lo = {ln.lo[DATA_WIDTH-2:0], 1'b0};
      return nx;
   endfunction

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      item_in = in_item;
      item_in.lane_x = step_lane(in_item.lane_x, in_item.divisor);
      item_in.lane_y = step_lane(in_item.lane_y, in_item.divisor);
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item = item_ff;

endmodule

### src/wdvr_back.sv
// Exit stage: quotient saturation, still-water check and the result register.
`timescale 1ns / 1ps

module wdvr_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  wdvr_pkg::item_type                     in_item,
   input  logic [wdvr_pkg::THR_WIDTH-1:0]         still_threshold,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [wdvr_pkg::DATA_WIDTH-1:0] rsp_depth_out,
   output logic signed [wdvr_pkg::DATA_WIDTH-1:0] rsp_momentum_x_out,
   output logic signed [wdvr_pkg::DATA_WIDTH-1:0] rsp_momentum_y_out,
   output logic signed [wdvr_pkg::DATA_WIDTH-1:0] rsp_velocity_x,
   output logic signed [wdvr_pkg::DATA_WIDTH-1:0] rsp_velocity_y,
   output logic                                   rsp_cell_dry,
   output logic                                   rsp_quotient_saturated
);
   import wdvr_pkg::*;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] vel;
      logic [DATA_WIDTH-1:0] mom;
      logic                  sat;
   } lane_result_type;

   logic                  valid_ff, valid_in;
   logic [DATA_WIDTH-1:0] depth_ff, depth_in;
   logic [DATA_WIDTH-1:0] mom_x_ff, mom_x_in;
   logic [DATA_WIDTH-1:0] mom_y_ff, mom_y_in;
   logic [DATA_WIDTH-1:0] vel_x_ff, vel_x_in;
   logic [DATA_WIDTH-1:0] vel_y_ff, vel_y_in;
   logic                  dry_ff, dry_in;
   logic                  sat_ff, sat_in;
   lane_result_type       res_x, res_y;

   function automatic lane_result_type finish_lane(input lane_type ln,
                                                   input logic [THR_WIDTH-1:0] thr);
      lane_result_type       res;
      logic [DATA_WIDTH-1:0] qs;
      logic                  sat;
      qs = ln.quo;
      sat = 1'b0;
      if (ln.mom == '0) begin
         qs = '0;
      end else if (ln.over) begin
         qs = ln.neg ? SAT_NEG : SAT_POS;
         sat = 1'b1;
      end else if (!ln.neg && ln.quo[DATA_WIDTH-1]) begin
         qs = SAT_POS;
         sat = 1'b1;
      end else if (ln.neg && (ln.quo > SAT_NEG)) begin
         qs = SAT_NEG;
         sat = 1'b1;
      end
      res.sat = sat;
      if (qs < {1'b0, thr}) begin
         res.vel = '0;
         res.mom = '0;
      end else begin
         res.vel = ln.neg ? (~qs + 1'b1) : qs;
         res.mom = ln.mom;
      end
      return res;
   endfunction

   assign in_ready = !valid_ff || rsp_ready;

   always_comb begin
      res_x = finish_lane(in_item.lane_x, still_threshold);
      res_y = finish_lane(in_item.lane_y, still_threshold);
      dry_in = in_item.dry;
      if (in_item.dry) begin
         depth_in = '0;
         mom_x_in = '0;
         mom_y_in = '0;
         vel_x_in = '0;
         vel_y_in = '0;
         sat_in = 1'b0;
      end else begin
         depth_in = in_item.depth;
         mom_x_in = res_x.mom;
         mom_y_in = res_y.mom;
         vel_x_in = res_x.vel;
         vel_y_in = res_y.vel;
         sat_in = res_x.sat || res_y.sat;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         depth_ff <= depth_in;
         mom_x_ff <= mom_x_in;
         mom_y_ff <= mom_y_in;
         vel_x_ff <= vel_x_in;
         vel_y_ff <= vel_y_in;
         dry_ff <= dry_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_depth_out = $signed(depth_ff);
   assign rsp_momentum_x_out = $signed(mom_x_ff);
   assign rsp_momentum_y_out = $signed(mom_y_ff);
   assign rsp_velocity_x = $signed(vel_x_ff);
   assign rsp_velocity_y = $signed(vel_y_ff);
   assign rsp_cell_dry = dry_ff;
   assign rsp_quotient_saturated = sat_ff;

endmodule

### src/wdvr_checker.sv
// Port-level checker for the wet/dry velocity recovery core and its bind.
`timescale 1ns / 1ps

module wdvr_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [wdvr_pkg::DATA_WIDTH-1:0] rsp_depth_out,
   input logic signed [wdvr_pkg::DATA_WIDTH-1:0] rsp_momentum_x_out,
   input logic signed [wdvr_pkg::DATA_WIDTH-1:0] rsp_momentum_y_out,
   input logic signed [wdvr_pkg::DATA_WIDTH-1:0] rsp_velocity_x,
   input logic signed [wdvr_pkg::DATA_WIDTH-1:0] rsp_velocity_y,
   input logic                                   rsp_cell_dry,
   input logic                                   rsp_quotient_saturated
);
   import wdvr_pkg::*;

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_velocity_x)
         && $stable(rsp_velocity_y) && $stable(rsp_momentum_x_out)
         && $stable(rsp_momentum_y_out) && $stable(rsp_depth_out))
      else $error("stalled result changed");

   a_dry_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cell_dry |-> rsp_depth_out == '0 && rsp_momentum_x_out == '0
         && rsp_momentum_y_out == '0 && rsp_velocity_x == '0 && rsp_velocity_y == '0
         && !rsp_quotient_saturated)
      else $error("dry cell with nonzero result");

   a_sign_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_velocity_x != '0 |-> rsp_momentum_x_out != '0
         && rsp_velocity_x[DATA_WIDTH-1] == rsp_momentum_x_out[DATA_WIDTH-1])
      else $error("x velocity disagrees with x momentum");

   a_sat_clipped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_quotient_saturated |->
         $unsigned(rsp_velocity_x) == SAT_POS || $unsigned(rsp_velocity_x) == SAT_NEG
         || $unsigned(rsp_velocity_y) == SAT_POS || $unsigned(rsp_velocity_y) == SAT_NEG)
      else $error("saturation flag without a clipped velocity");

endmodule

bind wet_dry_velocity_recovery_core wdvr_checker u_wdvr_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_depth_out         (rsp_depth_out),
   .rsp_momentum_x_out    (rsp_momentum_x_out),
   .rsp_momentum_y_out    (rsp_momentum_y_out),
   .rsp_velocity_x        (rsp_velocity_x),
   .rsp_velocity_y        (rsp_velocity_y),
   .rsp_cell_dry          (rsp_cell_dry),
   .rsp_quotient_saturated(rsp_quotient_saturated)
);
